### src/sdt_pkg.sv
package sdt_pkg;

	// byte codes of the text
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// parse phase
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_SIGNED = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;

	// result status
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	localparam int MAG_W = 34;
	localparam int CNT_W = 4;

	localparam logic [CNT_W-1:0] MAX_DIGITS = 4'd10;
	localparam logic [CNT_W-1:0] DIGIT_CAP  = 4'd11;

	localparam logic [MAG_W-1:0] POS_LIMIT = 34'd2147483647;
	localparam logic [MAG_W-1:0] NEG_LIMIT = 34'd2147483648;

	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

### src/sdt_if.sv
interface sdt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source(output valid, output ch, input ready);
	modport sink(input valid, input ch, output ready);
endinterface

interface sdt_result_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] value;
	logic [1:0]        status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

### src/strict_decimal_text_to_int32.sv
// Strict decimal text to signed 32-bit integer. The text arrives one ASCII byte per item on
// "text" and a zero byte ends it; the block then gives one item on "result" holding the value
// and a status (ok, invalid text, overflow). Accepted text: an optional '+' or '-', at least one
// digit, then the terminator; any other byte makes the whole string invalid, and invalid wins
// over overflow. More than ten digits (leading zeros count) or a value outside the int32 range
// is overflow; value reads zero whenever status is not ok. Throughput is one byte per cycle,
// save for the terminator stall below: each byte is held in an input register and folded into
// the running magnitude in the next cycle by one shift-and-add multiply by ten; the terminator's
// result goes from the input register into the output register. The output register lets the next string
// start streaming while a result waits; only a terminator that finds the output register still
// full holds the input back. No clearing pass is needed after reset.
module strict_decimal_text_to_int32
	import sdt_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	sdt_byte_if.sink     text,
	sdt_result_if.source result
);

	// input stage
	logic       valid_s1;
	logic [7:0] ch_s1;

	// parse state
	logic [1:0] phase_q;
	logic       neg_q;
	mag_t       mag_q;
	cnt_t       cnt_q;
	logic       bad_q;

	// result register
	logic              out_valid_q;
	logic signed [31:0] value_q;
	logic [1:0]        status_q;

	logic       is_term;
	logic       is_digit;
	logic       is_sign;
	logic       adv_s1;
	logic       take_term;
	logic [3:0] digit;
	mag_t       mag_next;
	logic       ovf;
	logic [1:0] res_status;
	logic [31:0] res_value;

	always_comb begin
		is_term  = (ch_s1 == CH_NUL);
		is_digit = ch_s1 inside {[CH_ZERO:CH_NINE]};
		is_sign  = (ch_s1 == CH_PLUS) || (ch_s1 == CH_MINUS);
		// a terminator must find room in the result register; other bytes always move on
		adv_s1    = valid_s1 && (!is_term || !out_valid_q || result.ready);
		take_term = adv_s1 && is_term;
		digit     = 4'(ch_s1 - CH_ZERO);
		// times ten as eight plus two, plus the new digit
		mag_next  = {mag_q[MAG_W-4:0], 3'b000} + {mag_q[MAG_W-2:0], 1'b0}
			+ MAG_W'(digit);
		ovf = (cnt_q > MAX_DIGITS) || (neg_q && mag_q > NEG_LIMIT)
			|| (!neg_q && mag_q > POS_LIMIT);
		res_value = '0;
		if (bad_q || phase_q != PH_DIGITS) begin
			res_status = ST_BAD;
		end else if (ovf) begin
			res_status = ST_OVF;
		end else begin
			res_status = ST_OK;
			res_value  = neg_q ? (32'd0 - mag_q[31:0]) : mag_q[31:0];
		end
	end

	assign text.ready    = !valid_s1 || adv_s1;
	assign result.valid  = out_valid_q;
	assign result.value  = value_q;
	assign result.status = status_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready) begin
			ch_s1 <= text.ch;
		end
	end

	// parse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			cnt_q   <= '0;
			bad_q   <= 1'b0;
		end else if (adv_s1) begin
			if (is_term) begin
				// ready for the next string
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				mag_q   <= '0;
				cnt_q   <= '0;
				bad_q   <= 1'b0;
			end else if (!bad_q) begin
				if (is_digit) begin
					// magnitude freezes past the tenth digit, count holds at its cap
					if (cnt_q < MAX_DIGITS) begin
						mag_q <= mag_next;
					end
					if (cnt_q < DIGIT_CAP) begin
						cnt_q <= cnt_q + 4'd1;
					end
					phase_q <= PH_DIGITS;
				end else if (is_sign && phase_q != PH_SIGNED && phase_q != PH_DIGITS) begin
					neg_q   <= (ch_s1 == CH_MINUS);
					phase_q <= PH_SIGNED;
				end else begin
					// stray byte: rest of the string ignored up to the terminator
					bad_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.ready || !out_valid_q) begin
			out_valid_q <= take_term;
		end
	end

	always_ff @(posedge clk) begin
		if (take_term) begin
			value_q  <= res_value;
			status_q <= res_status;
		end
	end

`ifndef SYNTHESIS
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIGIT_CAP)
		else $error("digit count beyond cap");

	a_term_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		take_term |=> out_valid_q)
		else $error("terminator did not produce an item");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take_term |=> (cnt_q == '0 && !bad_q && phase_q == PH_START && mag_q == '0))
		else $error("parse state not cleared after terminator");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (value_q == '0))
		else $error("value not zero on error status");
`endif

endmodule
